[sv/u8f_pkg.sv]
// Shared types, constants and result builders for the UTF-8 to UTF-16 filter.
// No dependencies; imported by every module of the block.
package u8f_pkg;

   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = 2;
   localparam int unsigned RSP_CNT_W = 3;

   localparam logic [15:0] MAX_UNITS_RESET = 16'd256;

   localparam logic [7:0] BYTE_NUL    = 8'h00;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_CODE  = 8'hE0;
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_CODE  = 8'hC0;

   typedef struct packed {
      logic [15:0] unit;
      logic        terminator;
      logic [15:0] unit_count;
      logic        truncated;
      logic        last_of_item;
   } rsp_type;

   // Results produced by one request, compacted: first result in r0.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
   } dec_out_type;

   function automatic rsp_type unit_rsp(input logic [15:0] unit);
      rsp_type r;
      r = '0;
      r.unit = unit;
      return r;
   endfunction

   function automatic rsp_type term_rsp(input logic [15:0] count, input logic trunc);
      rsp_type r;
      r = '0;
      r.terminator = 1'b1;
      r.unit_count = count;
      r.truncated  = trunc;
      r.last_of_item = 1'b1;
      return r;
   endfunction

endpackage

[sv/u8f_if.sv]
// Handshake channel interfaces for the request and response sides.
// Depends on nothing; used by the top level ports.
interface u8f_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface u8f_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] unit;
   logic        terminator;
   logic [15:0] unit_count;
   logic        truncated;
   logic        last_of_item;

   modport source (output valid, output unit, output terminator, output unit_count,
                   output truncated, output last_of_item, input ready);
   modport sink   (input valid, input unit, input terminator, input unit_count,
                   input truncated, input last_of_item, output ready);
endinterface

[sv/u8f_decode.sv]
// Decoder state and per-byte decode logic: turns one byte into zero to two results.
// Depends on u8f_pkg.
module u8f_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            data_byte,
   input  logic                  end_of_buffer,
   input  logic [15:0]           max_units,
   output u8f_pkg::dec_out_type  dec_out
);
   import u8f_pkg::*;

   logic [1:0]  pend_ff, pend_in;
   logic [15:0] acc_ff, acc_in;
   logic [15:0] uw_ff, uw_in;
   logic        disc_ff, disc_in;

   logic        have_unit;
   logic [15:0] unit_val;
   logic        run_done;
   logic [15:0] limit;
   logic        printable;

   assign limit = max_units - 16'd1;
   assign printable = (data_byte == BYTE_CR) || (data_byte == BYTE_LF) ||
                      (!data_byte[7] && (data_byte[6:5] != 2'b00));

   always_comb begin
      pend_in   = pend_ff;
      acc_in    = acc_ff;
      uw_in     = uw_ff;
      disc_in   = disc_ff;
      have_unit = 1'b0;
      unit_val  = '0;
      run_done  = 1'b0;
      dec_out   = '0;

      if (disc_ff) begin
         if (end_of_buffer) begin
            disc_in = 1'b0;
         end
      end else begin
         priority if (pend_ff != 2'd0) begin
            acc_in    = {acc_ff[9:0], data_byte[5:0]};
            pend_in   = pend_ff - 2'd1;
            have_unit = (pend_ff == 2'd1);
            unit_val  = acc_in;
         end else if (data_byte == BYTE_NUL) begin
            dec_out.count = 2'd1;
            dec_out.r0    = term_rsp(uw_ff, 1'b0);
            run_done      = 1'b1;
         end else if (printable) begin
            have_unit = 1'b1;
            unit_val  = {8'd0, data_byte};
         end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
            acc_in  = {12'd0, data_byte[3:0]};
            pend_in = 2'd2;
         end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
            acc_in  = {11'd0, data_byte[4:0]};
            pend_in = 2'd1;
         end else begin
            // skip any other byte
            acc_in = acc_ff;
         end

         if (!run_done) begin
            if (have_unit && (uw_ff == limit)) begin
               // replace the unit that would overflow capacity
               dec_out.count = 2'd1;
               dec_out.r0    = term_rsp(uw_ff, 1'b1);
               run_done      = 1'b1;
            end else if (have_unit) begin
               uw_in         = uw_ff + 16'd1;
               dec_out.count = 2'd1;
               dec_out.r0    = unit_rsp(unit_val);
               if (end_of_buffer) begin
                  dec_out.count = 2'd2;
                  dec_out.r1    = term_rsp(uw_in, 1'b0);
                  run_done      = 1'b1;
               end else begin
                  dec_out.r0.last_of_item = 1'b1;
               end
            end else if (end_of_buffer) begin
               dec_out.count = 2'd1;
               dec_out.r0    = term_rsp(uw_ff, 1'b0);
               run_done      = 1'b1;
            end
         end

         if (run_done) begin
            pend_in = '0;
            acc_in  = '0;
            uw_in   = '0;
            disc_in = !end_of_buffer;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         acc_ff  <= '0;
         uw_ff   <= '0;
         disc_ff <= 1'b0;
      end else if (advance) begin
         pend_ff <= pend_in;
         acc_ff  <= acc_in;
         uw_ff   <= uw_in;
         disc_ff <= disc_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3) else $error("pending count out of range");
   a_disc_clean: assert property (@(posedge clock) disable iff (reset)
      disc_ff |-> (pend_ff == 2'd0 && acc_ff == 16'd0 && uw_ff == 16'd0))
      else $error("discarding with live run state");
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(uw_ff) && $stable(pend_ff))
      else $error("decoder state moved without a request");
`endif
endmodule

[sv/u8f_rsp_fifo.sv]
// Result queue: takes up to two results per cycle while it has room, hands out one per cycle while out_ready is high.
// Depends on u8f_pkg.
module u8f_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  u8f_pkg::dec_out_type  push,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output u8f_pkg::rsp_type      out_data
);
   import u8f_pkg::*;

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ff, wr_in;
   logic [RSP_PTR_W-1:0]   rd_ff, rd_in;
   logic [RSP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   pop;

   assign room      = (cnt_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = wr_ff + RSP_PTR_W'(push.count);
      rd_in  = rd_ff + RSP_PTR_W'(pop);
      cnt_in = cnt_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + RSP_PTR_W'(1)] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RSP_CNT_W'(RSP_DEPTH)) else $error("result queue overfilled");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room) else $error("push without room");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ff == rd_ff)) else $error("pointers disagree with count");
`endif
endmodule

[sv/utf8_to_utf16_filter.sv]
// Top level of the UTF-8 to UTF-16 filter: request register, decoder, result queue.
// Depends on u8f_pkg, u8f_if, u8f_decode and u8f_rsp_fifo.
//
// Usage: req_chan carries one UTF-8 byte per request with end_of_buffer on the
// final byte of a buffer. rsp_chan returns UTF-16 units and, per run, one
// terminator result with the unit count and the capacity flag. last_of_item
// marks the final result of a byte; bytes that give no result give nothing.
// csr_wr_en/csr_wr_data write max_units (reset 256); write it only when idle.
// Path: a taken request is held in the request register, is decoded and written
// into the 4-entry result queue once two entries are free, and is then on rsp_chan.
// Throughput: one byte per cycle while the queue has room, set by the single
// decode pass between the request register and the queue; a byte that gives two
// results (unit plus terminator) needs two response transfers, which the queue
// absorbs.
// Reset clears the run state and the queue and loads max_units with 256.
// When the receiver stalls, results wait in the queue; the request register
// holds its byte once fewer than two queue entries are free, and req ready drops.
module utf8_to_utf16_filter (
   input  logic          clock,
   input  logic          reset,
   u8f_req_if.sink       req_chan,
   u8f_rsp_if.source     rsp_chan,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data
);
   import u8f_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_eob_ff;
   logic [15:0] max_units_ff;
   logic        s1_go;
   logic        room;
   logic        take;
   dec_out_type dec_out;
   dec_out_type push;
   rsp_type     out_data;

   assign s1_go          = s1_valid_ff && room;
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign take           = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = take || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         max_units_ff <= MAX_UNITS_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_wr_en) begin
            max_units_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_eob_ff  <= req_chan.end_of_buffer;
      end
   end

   u8f_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .advance       (s1_go),
      .data_byte     (s1_byte_ff),
      .end_of_buffer (s1_eob_ff),
      .max_units     (max_units_ff),
      .dec_out       (dec_out)
   );

   always_comb begin
      push = dec_out;
      if (!s1_go) begin
         push.count = 2'd0;
      end
   end

   u8f_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.unit         = out_data.unit;
   assign rsp_chan.terminator   = out_data.terminator;
   assign rsp_chan.unit_count   = out_data.unit_count;
   assign rsp_chan.truncated    = out_data.truncated;
   assign rsp_chan.last_of_item = out_data.last_of_item;

`ifndef NO_ASSERTIONS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_eob_ff))
      else $error("request register lost a stalled request");
   a_no_take_full: assert property (@(posedge clock) disable iff (reset)
      take |-> (!s1_valid_ff || room)) else $error("request taken over a held one");
   a_term_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.terminator |-> rsp_chan.last_of_item)
      else $error("terminator not marked last of its request");
`endif
endmodule
